// ===== hdl/quantized_dot_product_with_zero_points_defines.svh =====
`ifndef QUANTIZED_DOT_PRODUCT_WITH_ZERO_POINTS_DEFINES_SVH
`define QUANTIZED_DOT_PRODUCT_WITH_ZERO_POINTS_DEFINES_SVH

// same-cycle implication
`define QDP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define QDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/qdp_pkg.sv =====
package qdp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_AW      = 3;
  localparam int TERM_W      = 19;
  localparam int ACC_W       = 40;

  localparam logic [CFG_AW-1:0] ADDR_WEIGHT_SIGNED  = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_ACT_ZERO_POINT = 3'd4;

  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic [31:0]              scale;
    logic                     last;
  } qdp_entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } qdp_queue_status_t;

endpackage

// ===== hdl/quantized_dot_product_with_zero_points.sv =====
// Streams one activation/weight element per cycle, while the queue has room,
// into a signed 40-bit accumulator saturating at the 40-bit bounds; on the
// element marked last it returns the sum saturated to 32 bits with an overflow
// flag plus that sum times the unsigned Q16.16 scale. The front stage forms
// each element's product and writes it into a QUEUE_DEPTH-entry queue; the
// back end pops one entry per cycle through its single add-and-saturate
// accumulator loop, which sets the sustained rate of one element per cycle,
// except that a last element waits while the result register cannot drain.
// A result moves from the queue to the sum register, then the scaled output
// register. While an unread result holds the output, the accumulator keeps
// taking elements of the next row, and the queue absorbs the rest.
module quantized_dot_product_with_zero_points import qdp_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         act_value_i,
  input  logic [7:0]         weight_byte_i,
  input  logic signed [8:0]  weight_zero_i,
  input  logic [31:0]        scale_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] dot_sum_o,
  output logic               overflow_o,
  output logic signed [63:0] scaled_value_o
);

  qdp_queue_status_t queue_status;
  qdp_entry_t        entry_in;
  qdp_entry_t        head;
  logic              push;
  logic              pop;

  qdp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .act_value_i    (act_value_i),
    .weight_byte_i  (weight_byte_i),
    .weight_zero_i  (weight_zero_i),
    .scale_i        (scale_i),
    .last_i         (last_i),
    .queue_status_i (queue_status),
    .push_o         (push),
    .entry_o        (entry_in)
  );

  qdp_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry_in),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (queue_status)
  );

  qdp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .queue_status_i (queue_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dot_sum_o      (dot_sum_o),
    .overflow_o     (overflow_o),
    .scaled_value_o (scaled_value_o)
  );

endmodule

// ===== hdl/qdp_front.sv =====
module qdp_front import qdp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_AW-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              act_value_i,
  input  logic [7:0]              weight_byte_i,
  input  logic signed [8:0]       weight_zero_i,
  input  logic [31:0]             scale_i,
  input  logic                    last_i,
  input  qdp_queue_status_t       queue_status_i,
  output logic                    push_o,
  output qdp_entry_t              entry_o
);

  logic                     weight_signed_q;
  logic [7:0]               act_zero_point_q;
  logic                     cfg_write;
  logic signed [8:0]        act_diff;
  logic signed [8:0]        weight_val;
  logic signed [9:0]        weight_diff;
  logic signed [TERM_W-1:0] term;

  function automatic logic signed [8:0] weight_signed_i_ext(logic [7:0] b, logic is_signed);
    return is_signed ? $signed({b[7], b}) : $signed({1'b0, b});
  endfunction

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_signed_q  <= 1'b1;
      act_zero_point_q <= 8'd0;
    end else if (cfg_write) begin
      case (paddr)
        ADDR_WEIGHT_SIGNED:  weight_signed_q  <= pwdata[0];
        ADDR_ACT_ZERO_POINT: act_zero_point_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_WEIGHT_SIGNED:  prdata = {31'd0, weight_signed_q};
      ADDR_ACT_ZERO_POINT: prdata = {24'd0, act_zero_point_q};
      default:             prdata = 32'd0;
    endcase
  end

  assign act_diff    = $signed({1'b0, act_value_i}) - $signed({1'b0, act_zero_point_q});
  assign weight_val  = weight_signed_i_ext(weight_byte_i, weight_signed_q);
  assign weight_diff = 10'(weight_val) - 10'(weight_zero_i);
  assign term        = TERM_W'(act_diff) * TERM_W'(weight_diff);

  assign in_ready_o     = !queue_status_i.full;
  assign push_o         = in_valid_i && in_ready_o;
  assign entry_o.term   = term;
  assign entry_o.scale  = scale_i;
  assign entry_o.last   = last_i;

endmodule

// ===== hdl/qdp_queue.sv =====
module qdp_queue import qdp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qdp_entry_t        entry_i,
  input  logic              pop_i,
  output qdp_entry_t        head_o,
  output qdp_queue_status_t status_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  qdp_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o             = mem_q[rd_ptr_q];
  assign status_o.not_empty = (count_q != '0);
  assign status_o.full      = (count_q == CNT_W'(DEPTH));

endmodule

// ===== hdl/qdp_back.sv =====
module qdp_back import qdp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qdp_entry_t          head_i,
  input  qdp_queue_status_t   queue_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  dot_sum_o,
  output logic                overflow_o,
  output logic signed [63:0]  scaled_value_o
);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W:0]   sum_wide;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [31:0]      sum32;
  logic                    ovf32;

  logic                    r_vld_q, r_vld_d;
  logic signed [31:0]      r_sum_q;
  logic                    r_ovf_q;
  logic [31:0]             r_scale_q;
  logic                    r_move;

  logic                    o_vld_q, o_vld_d;
  logic signed [31:0]      o_sum_q;
  logic                    o_ovf_q;
  logic signed [63:0]      o_scaled_q;
  logic signed [65:0]      product;

  assign r_move = r_vld_q && (!o_vld_q || out_ready_i);
  assign pop_o  = queue_status_i.not_empty && (!head_i.last || !r_vld_q || r_move);

  assign sum_wide = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(head_i.term);

  always_comb begin
    case (sum_wide[ACC_W:ACC_W-1])
      2'b01:   acc_sat = {1'b0, {(ACC_W - 1){1'b1}}};
      2'b10:   acc_sat = {1'b1, {(ACC_W - 1){1'b0}}};
      default: acc_sat = sum_wide[ACC_W-1:0];
    endcase
    if (acc_sat[ACC_W-1:31] == '0 || acc_sat[ACC_W-1:31] == '1) begin
      sum32 = acc_sat[31:0];
      ovf32 = 1'b0;
    end else begin
      sum32 = acc_sat[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      ovf32 = 1'b1;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (pop_o) begin
      acc_d = head_i.last ? '0 : acc_sat;
    end
    r_vld_d = r_vld_q;
    if (pop_o && head_i.last) begin
      r_vld_d = 1'b1;
    end else if (r_move) begin
      r_vld_d = 1'b0;
    end
    o_vld_d = o_vld_q;
    if (r_move) begin
      o_vld_d = 1'b1;
    end else if (out_ready_i) begin
      o_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      r_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      r_vld_q <= r_vld_d;
      o_vld_q <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) begin
      r_sum_q   <= sum32;
      r_ovf_q   <= ovf32;
      r_scale_q <= head_i.scale;
    end
  end

  assign product = 66'(r_sum_q) * $signed({34'd0, r_scale_q});

  always_ff @(posedge clk_i) begin
    if (r_move) begin
      o_sum_q    <= r_sum_q;
      o_ovf_q    <= r_ovf_q;
      o_scaled_q <= product[63:0];
    end
  end

  assign out_valid_o    = o_vld_q;
  assign dot_sum_o      = o_sum_q;
  assign overflow_o     = o_ovf_q;
  assign scaled_value_o = o_scaled_q;

endmodule

// ===== hdl/qdp_checker.sv =====
`include "quantized_dot_product_with_zero_points_defines.svh"

module qdp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pready,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] dot_sum_o,
  input logic               overflow_o,
  input logic signed [63:0] scaled_value_o
);

  `QDP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(dot_sum_o) && $stable(scaled_value_o) && $stable(overflow_o))
  `QDP_ASSERT_IMPLY(a_ovf_bound, clk_i, rst_ni, out_valid_o && overflow_o, dot_sum_o == 32'sh7fff_ffff || dot_sum_o == 32'sh8000_0000)
  `QDP_ASSERT_IMPLY(a_zero_scaled, clk_i, rst_ni, out_valid_o && dot_sum_o == 32'sd0, scaled_value_o == 64'sd0)
  `QDP_ASSERT_IMPLY(a_sign_scaled, clk_i, rst_ni, out_valid_o && !dot_sum_o[31], !scaled_value_o[63] && pready)

endmodule

bind quantized_dot_product_with_zero_points qdp_checker u_qdp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pready         (pready),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .dot_sum_o      (dot_sum_o),
  .overflow_o     (overflow_o),
  .scaled_value_o (scaled_value_o)
);

// ===== verif/tb_quantized_dot_product_with_zero_points.sv =====
module tb_quantized_dot_product_with_zero_points import qdp_pkg::*;;

  localparam int     HALF_PERIOD  = 10;
  localparam int     DRAIN_CYCLES = 24;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam longint ACC_HI       = (longint'(1) <<< 39) - 1;
  localparam longint ACC_LO       = -ACC_HI - 1;
  localparam longint SUM_HI       = 64'sd2147483647;
  localparam longint SUM_LO       = -64'sd2147483648;

  typedef struct packed {
    logic [7:0]        act;
    logic [7:0]        wbyte;
    logic signed [8:0] wzero;
    logic [31:0]       scale;
    logic              last;
  } element_t;

  typedef struct packed {
    logic signed [31:0] dot_sum;
    logic               overflow;
    logic signed [63:0] scaled;
  } dot_result_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [CFG_AW-1:0]   paddr          = '0;
  logic [31:0]         pwdata         = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [7:0]          act_value_i    = '0;
  logic [7:0]          weight_byte_i  = '0;
  logic signed [8:0]   weight_zero_i  = '0;
  logic [31:0]         scale_i        = '0;
  logic                last_i         = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic signed [31:0]  dot_sum_o;
  logic                overflow_o;
  logic signed [63:0]  scaled_value_o;

  quantized_dot_product_with_zero_points DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .act_value_i    (act_value_i),
    .weight_byte_i  (weight_byte_i),
    .weight_zero_i  (weight_zero_i),
    .scale_i        (scale_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dot_sum_o      (dot_sum_o),
    .overflow_o     (overflow_o),
    .scaled_value_o (scaled_value_o)
  );

  logic        cfg_weight_signed = 1'b1;
  logic [7:0]  cfg_act_zp        = 8'd0;
  longint      mac_acc           = 0;
  dot_result_t pending_results[$];
  int          mismatch_count    = 0;
  int          cycle_count       = 0;
  int          burst_left        = 0;
  bit          steady_send       = 1'b0;
  int          hold_request      = 0;
  int          hold_served       = 0;
  int          hold_cnt          = 0;
  int          rx_mode           = 0;
  int          rx_left           = 0;

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quantized_dot_product_with_zero_points verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_request != hold_served) begin
      hold_served <= hold_request;
      hold_cnt    <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(5, 60);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  always @(posedge clk_i) begin : check_result
    dot_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with no request pending: sum %0d ovf %0b scaled %0d",
                                dot_sum_o, overflow_o, scaled_value_o));
      end else begin
        want = pending_results.pop_front();
        if (dot_sum_o !== want.dot_sum || overflow_o !== want.overflow ||
            scaled_value_o !== want.scaled) begin
          flag_mismatch($sformatf({"expected sum %0d ovf %0b scaled %0d, ",
                                   "got sum %0d ovf %0b scaled %0d"},
                                  want.dot_sum, want.overflow, want.scaled,
                                  dot_sum_o, overflow_o, scaled_value_o));
        end
      end
    end
  end

  function automatic void predict_mac(input element_t e);
    int          a;
    int          w;
    longint      acc;
    longint      s;
    dot_result_t r;
    a   = int'(e.act) - int'(cfg_act_zp);
    w   = cfg_weight_signed ? int'($signed(e.wbyte)) : int'(e.wbyte);
    w   = w - int'($signed(e.wzero));
    acc = mac_acc + longint'(a) * longint'(w);
    if (acc > ACC_HI) acc = ACC_HI;
    if (acc < ACC_LO) acc = ACC_LO;
    mac_acc = acc;
    if (e.last) begin
      s          = acc;
      r.overflow = 1'b0;
      if (s > SUM_HI) begin
        s          = SUM_HI;
        r.overflow = 1'b1;
      end else if (s < SUM_LO) begin
        s          = SUM_LO;
        r.overflow = 1'b1;
      end
      r.dot_sum = s[31:0];
      r.scaled  = s * longint'({32'b0, e.scale});
      pending_results.push_back(r);
      mac_acc = 0;
    end
  endfunction

  function automatic element_t make_element(input logic [7:0] act, input logic [7:0] wbyte,
                                            input logic [8:0] wzero, input logic [31:0] scale,
                                            input logic last);
    element_t e;
    e.act   = act;
    e.wbyte = wbyte;
    e.wzero = wzero;
    e.scale = scale;
    e.last  = last;
    return e;
  endfunction

  function automatic element_t rand_element(input logic last);
    element_t e;
    e.act   = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                           : 8'($urandom);
    e.wbyte = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'h80 : 8'h7F)
                                           : 8'($urandom);
    case ($urandom_range(0, 9))
      0:       e.wzero = 9'h100;
      1:       e.wzero = 9'h180;
      2:       e.wzero = 9'h0FF;
      3:       e.wzero = 9'h000;
      default: e.wzero = 9'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       e.scale = 32'h0000_0000;
      1:       e.scale = 32'hFFFF_FFFF;
      2:       e.scale = 32'h0001_0000;
      default: e.scale = $urandom;
    endcase
    e.last = last;
    return e;
  endfunction

  task automatic send_element(input element_t e);
    int gap;
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid_i    <= 1'b1;
    act_value_i   <= e.act;
    weight_byte_i <= e.wbyte;
    weight_zero_i <= e.wzero;
    scale_i       <= e.scale;
    last_i        <= e.last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_mac(e);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic [CFG_AW-1:0] addr, input logic wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic ws, input logic [7:0] azp);
    logic [31:0] rd;
    apb_access(ADDR_WEIGHT_SIGNED, 1'b1, {$urandom} & ~32'h1 | {31'b0, ws}, rd);
    apb_access(ADDR_ACT_ZERO_POINT, 1'b1, {$urandom} & ~32'hFF | {24'b0, azp}, rd);
    cfg_weight_signed = ws;
    cfg_act_zp        = azp;
    apb_access(ADDR_WEIGHT_SIGNED, 1'b0, 32'h0, rd);
    if (rd[0] !== ws)
      flag_mismatch($sformatf("weight_signed readback expected %0b got %0b", ws, rd[0]));
    apb_access(ADDR_ACT_ZERO_POINT, 1'b0, 32'h0, rd);
    if (rd[7:0] !== azp)
      flag_mismatch($sformatf("act_zero_point readback expected %0d got %0d", azp, rd[7:0]));
  endtask

  task automatic test_reset_defaults();
    send_element(make_element(8'hFF, 8'h7F, 9'h100, 32'hFFFF_FFFF, 1'b1));
    send_element(make_element(8'h00, 8'h80, 9'h0FF, 32'h0001_0000, 1'b1));
    send_element(make_element(8'hFF, 8'h80, 9'h0FF, 32'h0000_0001, 1'b1));
    send_element(make_element(8'h80, 8'hFF, 9'h000, 32'h0000_0000, 1'b1));
    send_element(make_element(8'h01, 8'h01, 9'h000, 32'h1234_5678, 1'b0));
    send_element(make_element(8'h02, 8'hFE, 9'h1FF, 32'h0000_0000, 1'b0));
    send_element(make_element(8'hFF, 8'h80, 9'h180, 32'hFFFF_FFFF, 1'b1));
    wait_idle();
  endtask

  task automatic test_weight_modes();
    set_config(1'b0, 8'hFF);
    send_element(make_element(8'h00, 8'hFF, 9'h100, 32'hFFFF_FFFF, 1'b1));
    send_element(make_element(8'hFF, 8'h00, 9'h000, 32'hFFFF_FFFF, 1'b1));
    send_element(make_element(8'h00, 8'h80, 9'h080, 32'h0000_0001, 1'b1));
    send_element(make_element(8'h11, 8'hC8, 9'h1FB, 32'h8000_0000, 1'b1));
    wait_idle();
    set_config(1'b1, 8'hFF);
    send_element(make_element(8'h00, 8'h80, 9'h0FF, 32'hFFFF_FFFF, 1'b1));
    send_element(make_element(8'h7F, 8'h7F, 9'h100, 32'h0001_0000, 1'b0));
    send_element(make_element(8'hFF, 8'hFF, 9'h0FF, 32'h0002_8000, 1'b1));
    wait_idle();
  endtask

  task automatic test_back_pressure();
    steady_send = 1'b1;
    set_config(1'b1, 8'h80);
    hold_request <= hold_request + 1;
    for (int i = 0; i < 80; i++) send_element(rand_element($urandom_range(0, 1)));
    send_element(rand_element(1'b1));
    wait_idle();
    steady_send = 1'b0;
  endtask

  task automatic test_random_rows();
    logic       ws;
    logic [7:0] azp;
    int         row_len;
    int         sent;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin ws = 1'b1; azp = 8'h00; end
        1:       begin ws = 1'b0; azp = 8'hFF; end
        2:       begin ws = 1'b1; azp = 8'hFF; end
        3:       begin ws = 1'b0; azp = 8'h00; end
        default: begin ws = 1'($urandom); azp = 8'($urandom); end
      endcase
      set_config(ws, azp);
      steady_send = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 230) begin
        row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        for (int i = 0; i < row_len; i++) send_element(rand_element(i == row_len - 1));
        sent += row_len;
      end
      wait_idle();
    end
    steady_send = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_weight_modes();
    test_back_pressure();
    test_random_rows();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("quantized_dot_product_with_zero_points verification clean");
    end else begin
      $display("quantized_dot_product_with_zero_points verification failed");
    end
    $finish;
  end

endmodule

// ===== quantized_dot_product_with_zero_points.f =====
+incdir+hdl
hdl/qdp_pkg.sv
hdl/qdp_front.sv
hdl/qdp_queue.sv
hdl/qdp_back.sv
hdl/quantized_dot_product_with_zero_points.sv
hdl/qdp_checker.sv
verif/tb_quantized_dot_product_with_zero_points.sv
